// File: sv/ekfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ekfp_pkg;

  typedef enum logic [1:0] {
    StepNone = 2'd0,
    StepUp   = 2'd1,
    StepDown = 2'd2
  } step_e;

  typedef enum logic [1:0] {
    CfgAdjustCurrent = 2'd0,
    CfgSingleRail    = 2'd1,
    CfgTrackingOn    = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] EncRest    = 2'd3;
  localparam logic [1:0] EncFromUp  = 2'd1;
  localparam logic [1:0] EncFromDn  = 2'd2;
  localparam logic [1:0] KeysIdle   = 2'b11;
  localparam logic [7:0] BounceIdle = 8'hFF;
  localparam logic [7:0] BounceArm  = 8'hFE;
  localparam logic [6:0] SizeOne     = 7'd1;
  localparam logic [6:0] SizeTen     = 7'd10;
  localparam logic [6:0] SizeHundred = 7'd100;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic adjust_current;
    logic single_rail;
    logic tracking_on;
  } cfg_t;

  typedef struct packed {
    step_e      ch1_step;
    step_e      ch2_step;
    logic [1:0] clean_keys;
    logic [1:0] keys_changed;
  } cls_t;

endpackage

`default_nettype wire

// File: sv/ekfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ekfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        enc1_pins_i,
  input  logic [1:0]        enc2_pins_i,
  input  logic [1:0]        raw_keys_i,
  input  logic              single_rail_i,
  input  logic              full_i,
  output logic              push_o,
  output ekfp_pkg::cls_t    push_data_o
);
  import ekfp_pkg::*;

  logic [1:0] prev_one_q, prev_one_d;
  logic [1:0] prev_two_q, prev_two_d;
  logic [1:0] stable_q, stable_d;
  logic [7:0] bounce_q, bounce_d;
  logic [1:0] changed;

  function automatic step_e decode_move(input logic [1:0] prev, input logic [1:0] cur);
    step_e res;
    res = StepNone;
    if (cur != prev && cur == EncRest) begin
      case (prev)
        EncFromUp: res = StepUp;
        EncFromDn: res = StepDown;
        default:   res = StepNone;
      endcase
    end
    return res;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    prev_one_d = prev_one_q;
    prev_two_d = prev_two_q;
    stable_d   = stable_q;
    bounce_d   = bounce_q;
    changed    = 2'b00;
    if (push_o) begin
      prev_one_d = enc1_pins_i;
      prev_two_d = enc2_pins_i;
      if (raw_keys_i != stable_q) begin
        if (bounce_q == BounceIdle) begin
          bounce_d = BounceArm;
        end else if (bounce_q != 8'd0) begin
          bounce_d = bounce_q >> 1;
        end else begin
          changed  = raw_keys_i ^ stable_q;
          stable_d = raw_keys_i;
          bounce_d = BounceIdle;
        end
      end else begin
        bounce_d = BounceIdle;
      end
    end
    push_data_o.ch1_step     = decode_move(prev_one_q, enc1_pins_i);
    push_data_o.ch2_step     = single_rail_i ? StepNone : decode_move(prev_two_q, enc2_pins_i);
    push_data_o.clean_keys   = stable_d;
    push_data_o.keys_changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_one_q <= EncRest;
      prev_two_q <= EncRest;
      stable_q   <= KeysIdle;
      bounce_q   <= BounceIdle;
    end else begin
      prev_one_q <= prev_one_d;
      prev_two_q <= prev_two_d;
      stable_q   <= stable_d;
      bounce_q   <= bounce_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ekfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ekfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ekfp_pkg::cls_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ekfp_pkg::cls_t  data_o,
  output logic            empty_o
);
  import ekfp_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && !empty_o)) begin
      count_d = count_q + QCntW'(1);
    end else if (!push_i && pop_i && !empty_o) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ekfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ekfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ekfp_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  ekfp_pkg::cls_t  data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      ch1_step_o,
  output logic [1:0]      ch2_step_o,
  output logic            adjusts_current_o,
  output logic [6:0]      step_size_one_o,
  output logic [6:0]      step_size_two_o,
  output logic [1:0]      clean_keys_o,
  output logic [1:0]      keys_changed_o
);
  import ekfp_pkg::*;

  logic [6:0] size_one_q, size_one_d;
  logic [6:0] size_two_q, size_two_d;
  logic       out_valid_q;
  cls_t       res_q;
  logic       adj_q;

  function automatic logic [6:0] next_size(input logic [6:0] s);
    logic [6:0] res;
    if (s == SizeOne) begin
      res = SizeTen;
    end else if (s == SizeTen) begin
      res = SizeHundred;
    end else begin
      res = SizeOne;
    end
    return res;
  endfunction

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    size_one_d = size_one_q;
    size_two_d = size_two_q;
    if (data_i.keys_changed[0] && data_i.clean_keys[0]) begin
      size_one_d = next_size(size_one_d);
      if (cfg_i.tracking_on) begin
        size_two_d = size_one_d;
      end
    end
    if (data_i.keys_changed[1] && !cfg_i.single_rail && data_i.clean_keys[1]) begin
      size_two_d = next_size(size_two_d);
      if (cfg_i.tracking_on) begin
        size_one_d = size_two_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_one_q  <= SizeOne;
      size_two_q  <= SizeOne;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        size_one_q  <= size_one_d;
        size_two_q  <= size_two_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= data_i;
      adj_q <= cfg_i.adjust_current;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ch1_step_o        = res_q.ch1_step;
  assign ch2_step_o        = res_q.ch2_step;
  assign adjusts_current_o = adj_q;
  assign step_size_one_o   = size_one_q;
  assign step_size_two_o   = size_two_q;
  assign clean_keys_o      = res_q.clean_keys;
  assign keys_changed_o    = res_q.keys_changed;

  a_size_one_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_one_q == SizeOne || size_one_q == SizeTen || size_one_q == SizeHundred)
    else $error("channel 1 step size out of cycle");

  a_size_two_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_two_q == SizeOne || size_two_q == SizeTen || size_two_q == SizeHundred)
    else $error("channel 2 step size out of cycle");

  a_pop_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped item did not reach output register");

  a_sizes_hold_without_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(size_one_q) && $stable(size_two_q))
    else $error("step sizes changed without an item");

endmodule

`default_nettype wire

// File: sv/encoder_key_front_panel_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Front panel input block for two quadrature encoders and two push keys. Each input
// item is one sample tick; each produces exactly one result item with the encoder steps,
// the debounced key state and the current step sizes. The block sustains one item per
// clock while results are taken: the front stage classifies a tick in the cycle it is
// accepted, a two-entry queue holds it, and the back stage applies the step-size update
// and loads the output register from the popped item, so each item is registered in the
// queue and then in the output register. While the output is held back, the queue absorbs
// two more items and then the input stalls until a result is taken.
// The configuration port is always ready; write it only while no item is in flight.

module encoder_key_front_panel_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] enc1_pins_i,
  input  logic [1:0] enc2_pins_i,
  input  logic [1:0] raw_keys_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] ch1_step_o,
  output logic [1:0] ch2_step_o,
  output logic       adjusts_current_o,
  output logic [6:0] step_size_one_o,
  output logic [6:0] step_size_two_o,
  output logic [1:0] clean_keys_o,
  output logic [1:0] keys_changed_o
);
  import ekfp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push, full, pop, empty;
  cls_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgAdjustCurrent: cfg_d.adjust_current = cfg_data_i;
        CfgSingleRail:    cfg_d.single_rail    = cfg_data_i;
        CfgTrackingOn:    cfg_d.tracking_on    = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ekfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .enc1_pins_i   (enc1_pins_i),
    .enc2_pins_i   (enc2_pins_i),
    .raw_keys_i    (raw_keys_i),
    .single_rail_i (cfg_q.single_rail),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ekfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  ekfp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .data_i            (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ch1_step_o        (ch1_step_o),
    .ch2_step_o        (ch2_step_o),
    .adjusts_current_o (adjusts_current_o),
    .step_size_one_o   (step_size_one_o),
    .step_size_two_o   (step_size_two_o),
    .clean_keys_o      (clean_keys_o),
    .keys_changed_o    (keys_changed_o)
  );

endmodule

`default_nettype wire
